/* hdl/scrgb_pkg.sv */
// ----------------------------------------------------------------------------
// scrgb_pkg
// Shared constants and types for the serial RGB command parser and PWM block.
// ----------------------------------------------------------------------------
package scrgb_pkg;

    localparam int BYTE_W       = 8;
    localparam int BUFFER_DEPTH = 16;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH);
    localparam int NUM_FIELDS   = 3;
    localparam int FIDX_W       = 2;
    localparam int DIGIT_W      = 4;
    localparam int Q_DEPTH      = 2;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int Q_CW         = $clog2(Q_DEPTH + 1);

    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_byte CHAR_HASH    = 8'h23;
    localparam t_byte CHAR_DOT     = 8'h2E;
    localparam t_byte CHAR_COMMA   = 8'h2C;
    localparam t_byte CHAR_ZERO    = 8'h30;
    localparam t_byte CHAR_NINE    = 8'h39;
    localparam t_byte PERIOD_RESET = 8'd255;
    localparam t_byte DEC_BASE     = 8'd10;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_HASH  = 3'd1,
        OP_OVF   = 3'd2,
        OP_DIGIT = 3'd3,
        OP_SEP   = 3'd4,
        OP_OTHER = 3'd5
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DIGIT_W-1:0] digit;
    } t_cmd;

endpackage

/* hdl/scrgb_in_if.sv */
// ----------------------------------------------------------------------------
// scrgb_in_if
// Input channel: serial byte or PWM tick, valid/ready handshake.
// ----------------------------------------------------------------------------
interface scrgb_in_if;
    import scrgb_pkg::*;

    logic  valid;
    logic  ready;
    logic  mode;
    t_byte rx_byte;

    modport source (output valid, mode, rx_byte, input ready);
    modport sink   (input valid, mode, rx_byte, output ready);
endinterface

/* hdl/scrgb_cfg_if.sv */
// ----------------------------------------------------------------------------
// scrgb_cfg_if
// Configuration write channel for the PWM period register.
// ----------------------------------------------------------------------------
interface scrgb_cfg_if;
    import scrgb_pkg::*;

    logic  valid;
    logic  ready;
    t_byte pwm_period;

    modport source (output valid, pwm_period, input ready);
    modport sink   (input valid, pwm_period, output ready);
endinterface

/* hdl/scrgb_out_if.sv */
// ----------------------------------------------------------------------------
// scrgb_out_if
// Result channel: frame flag, current duties and PWM pin levels.
// ----------------------------------------------------------------------------
interface scrgb_out_if;
    import scrgb_pkg::*;

    logic  valid;
    logic  ready;
    logic  frame_done;
    t_byte red_duty;
    t_byte green_duty;
    t_byte blue_duty;
    logic  red_pin;
    logic  green_pin;
    logic  blue_pin;

    modport source (output valid, frame_done, red_duty, green_duty, blue_duty,
                    red_pin, green_pin, blue_pin, input ready);
    modport sink   (input valid, frame_done, red_duty, green_duty, blue_duty,
                    red_pin, green_pin, blue_pin, output ready);
endinterface

/* hdl/scrgb_front.sv */
// ----------------------------------------------------------------------------
// scrgb_front
// Accepts input words, tracks frame length and classifies each word into a
// command for the back end.
// ----------------------------------------------------------------------------
module scrgb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scrgb_in_if.sink         i_in,
    input  logic             i_q_ready,
    output logic             o_push,
    output scrgb_pkg::t_cmd  o_cmd
);
    import scrgb_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             accept;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign o_push     = accept;

    always_comb begin
        o_cmd.op    = OP_OTHER;
        o_cmd.digit = DIGIT_W'(i_in.rx_byte - CHAR_ZERO);
        n_cnt       = r_cnt;
        priority if (i_in.mode) begin
            o_cmd.op = OP_TICK;
        end else if (i_in.rx_byte == CHAR_HASH) begin
            o_cmd.op = OP_HASH;
            n_cnt    = '0;
        end else if (r_cnt >= CNT_W'(BUFFER_DEPTH - 1)) begin
            o_cmd.op = OP_OVF;
            n_cnt    = '0;
        end else begin
            n_cnt = r_cnt + CNT_W'(1);
            if (i_in.rx_byte >= CHAR_ZERO && i_in.rx_byte <= CHAR_NINE) begin
                o_cmd.op = OP_DIGIT;
            end else if (i_in.rx_byte == CHAR_DOT || i_in.rx_byte == CHAR_COMMA) begin
                o_cmd.op = OP_SEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BUFFER_DEPTH - 1))
        else $error("frame count out of range");

    a_ovf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (o_cmd.op == OP_OVF || o_cmd.op == OP_HASH)) |=> (r_cnt == '0))
        else $error("frame count not cleared");

    a_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_cmd.op == OP_TICK) |=> $stable(r_cnt))
        else $error("tick changed frame count");

endmodule

/* hdl/scrgb_queue.sv */
// ----------------------------------------------------------------------------
// scrgb_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module scrgb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  scrgb_pkg::t_cmd  i_cmd,
    output logic             o_ready,
    output logic             o_valid,
    output scrgb_pkg::t_cmd  o_cmd,
    input  logic             i_pop
);
    import scrgb_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(do_push) - Q_CW'(do_pop);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue overfilled");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready))
        else $error("push into full queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers out of step");

endmodule

/* hdl/scrgb_back.sv */
// ----------------------------------------------------------------------------
// scrgb_back
// Executes commands: field parse, duty load, PWM counter and result register.
// ----------------------------------------------------------------------------
module scrgb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  scrgb_pkg::t_cmd  i_cmd,
    output logic             o_q_pop,
    scrgb_cfg_if.sink        i_cfg,
    scrgb_out_if.source      o_res
);
    import scrgb_pkg::*;

    t_byte             r_period;
    t_byte             r_acc;
    logic [FIDX_W-1:0] r_fidx;
    t_byte             r_fields [NUM_FIELDS];
    t_byte             r_duty   [NUM_FIELDS];
    t_byte             r_pwm;

    t_byte             n_acc;
    logic [FIDX_W-1:0] n_fidx;
    t_byte             n_fields [NUM_FIELDS];
    t_byte             n_duty   [NUM_FIELDS];
    t_byte             n_pwm;
    logic              n_done;

    logic              r_out_valid;
    logic              r_done;
    t_byte             r_out_duty [NUM_FIELDS];
    logic              r_out_pin  [NUM_FIELDS];

    logic              take;
    logic              fidx_ok;

    assign take       = i_q_valid && (!r_out_valid || o_res.ready);
    assign o_q_pop    = take;
    assign fidx_ok    = (r_fidx < FIDX_W'(NUM_FIELDS));
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_acc    = r_acc;
        n_fidx   = r_fidx;
        n_fields = r_fields;
        n_duty   = r_duty;
        n_pwm    = r_pwm;
        n_done   = 1'b0;
        unique case (i_cmd.op)
            OP_TICK: begin
                n_pwm = (r_pwm >= r_period) ? '0 : r_pwm + 8'd1;
            end
            OP_HASH: begin
                for (int k = 0; k < NUM_FIELDS; k++) begin
                    n_duty[k]   = (fidx_ok && r_fidx == FIDX_W'(k)) ? r_acc : r_fields[k];
                    n_fields[k] = '0;
                end
                n_acc  = '0;
                n_fidx = '0;
                n_done = 1'b1;
            end
            OP_OVF: begin
                for (int k = 0; k < NUM_FIELDS; k++) begin
                    n_fields[k] = '0;
                end
                n_acc  = '0;
                n_fidx = '0;
            end
            OP_DIGIT: begin
                if (fidx_ok) begin
                    n_acc = r_acc * DEC_BASE + BYTE_W'(i_cmd.digit);
                end
            end
            OP_SEP: begin
                if (fidx_ok) begin
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        if (r_fidx == FIDX_W'(k)) begin
                            n_fields[k] = r_acc;
                        end
                    end
                    n_fidx = r_fidx + FIDX_W'(1);
                    n_acc  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_acc       <= '0;
            r_fidx      <= '0;
            r_pwm       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_fields[k] <= '0;
                r_duty[k]   <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_period <= i_cfg.pwm_period;
            end
            if (take) begin
                r_acc       <= n_acc;
                r_fidx      <= n_fidx;
                r_pwm       <= n_pwm;
                r_fields    <= n_fields;
                r_duty      <= n_duty;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_done <= n_done;
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_out_duty[k] <= n_duty[k];
                r_out_pin[k]  <= (n_pwm < n_duty[k]);
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.frame_done = r_done;
    assign o_res.red_duty   = r_out_duty[0];
    assign o_res.green_duty = r_out_duty[1];
    assign o_res.blue_duty  = r_out_duty[2];
    assign o_res.red_pin    = r_out_pin[0];
    assign o_res.green_pin  = r_out_pin[1];
    assign o_res.blue_pin   = r_out_pin[2];

    a_hash_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.op == OP_HASH) |=> (r_fidx == '0 && r_acc == '0 && r_done))
        else $error("parse not restarted after frame end");

    a_tick_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.op == OP_TICK) |=> !r_done)
        else $error("frame flag on tick");

    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.op == OP_TICK && r_period == '0) |=> (r_pwm == '0))
        else $error("counter moved with zero period");

    a_fidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fidx <= FIDX_W'(NUM_FIELDS))
        else $error("field index out of range");

endmodule

/* hdl/serial_rgb_command_pwm_top.sv */
// ----------------------------------------------------------------------------
// serial_rgb_command_pwm_top
// Serial RGB frame parser ("R.G.B#") driving a three channel PWM generator.
//
//   port     dir  handshake      payload
//   i_in     in   valid/ready    mode, rx_byte
//   i_cfg    in   valid/ready    pwm_period
//   o_res    out  valid/ready    frame_done, red/green/blue_duty, *_pin
//
// One word per cycle unless o_res stalls; a word is queued, then registered.
// The front end owns the frame length count, the back end the field parse,
// duties and PWM counter; a two-entry queue between them absorbs stalls.
// Output stalls fill the result register and then the queue before i_in
// drops ready. Synchronous reset clears all parse state, duties and counter
// and sets the period to 255; no clearing pass.
// ----------------------------------------------------------------------------
module serial_rgb_command_pwm_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scrgb_in_if.sink     i_in,
    scrgb_cfg_if.sink    i_cfg,
    scrgb_out_if.source  o_res
);
    import scrgb_pkg::*;

    logic q_push;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    scrgb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (front_cmd)
    );

    scrgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (back_cmd),
        .i_pop   (q_pop)
    );

    scrgb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (back_cmd),
        .o_q_pop   (q_pop),
        .i_cfg     (i_cfg),
        .o_res     (o_res)
    );

endmodule
